[design/krl_pkg.sv]
package krl_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOGGLE,
    S_BUTTONS,
    S_SCAN,
    S_FINISH
  } state_t;

  localparam logic [7:0] TOGGLE_RESET = 8'd59;

  // left, right, up, down, Z, X, A, S
  function automatic logic [7:0] default_code(input int unsigned idx);
    logic [7:0] val;
    case (idx)
      0: val = 8'd203;
      1: val = 8'd205;
      2: val = 8'd200;
      3: val = 8'd208;
      4: val = 8'd44;
      5: val = 8'd45;
      6: val = 8'd30;
      7: val = 8'd31;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

[design/krl_ifs.sv]
interface krl_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_bits_0;
  logic [63:0] key_bits_1;
  logic [63:0] key_bits_2;
  logic [63:0] key_bits_3;

  modport source (output valid, key_bits_0, key_bits_1, key_bits_2, key_bits_3,
                  input ready);
  modport sink (input valid, key_bits_0, key_bits_1, key_bits_2, key_bits_3,
                output ready);
endinterface

interface krl_btn_if;
  logic       valid;
  logic       ready;
  logic [7:0] action_buttons;
  logic       learning;
  logic [3:0] next_slot;
  logic       mapping_done;

  modport source (output valid, action_buttons, learning, next_slot, mapping_done,
                  input ready);
  modport sink (input valid, action_buttons, learning, next_slot, mapping_done,
                output ready);
endinterface

[design/key_remap_with_learn_mode.sv]
// Flow: S_IDLE accepts a frame, S_TOGGLE looks up the toggle key, S_BUTTONS
// reads the action keys in normal mode or S_SCAN learns key codes in learn
// mode, then S_FINISH registers the result. One transaction at a time; the
// shared key lookup takes one key code per cycle.
// Reset (rst, synchronous): normal mode, slot 0, toggle key 59 seen as down,
// action table loaded with the default key codes.
module key_remap_with_learn_mode import krl_pkg::*; #(
  parameter int NUM_KEYS    = 256,
  parameter int NUM_ACTIONS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  krl_key_if.sink          key_in,
  krl_btn_if.source        btn_out
);

  localparam int KW = $clog2(NUM_KEYS);
  localparam int AW = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int SW = $clog2(NUM_ACTIONS + 1);

  state_t state, state_next;

  logic [7:0]          toggle_key_code;
  logic [NUM_KEYS-1:0] snap;
  logic [7:0]          action_key_table [NUM_ACTIONS];
  logic                toggle_was_down;
  logic                learn_mode;
  logic [SW-1:0]       slot;
  logic                tog_down;
  logic                tog_edge;
  logic [AW-1:0]       act;
  logic [KW-1:0]       code;
  logic [7:0]          buttons;
  logic                done;

  logic                out_valid;
  logic [7:0]          out_buttons;
  logic                out_learning;
  logic [3:0]          out_next_slot;
  logic                out_done;

  logic [7:0]          sel_code;
  logic                key_down;
  logic                taken;
  logic                hit;
  logic                accept;
  logic                out_free;
  logic [255:0]        in_bits;

  assign in_bits  = {key_in.key_bits_3, key_in.key_bits_2,
                     key_in.key_bits_1, key_in.key_bits_0};
  assign accept   = key_in.valid && key_in.ready;
  assign out_free = !out_valid || btn_out.ready;

  always_comb begin
    case (state)
      S_BUTTONS: sel_code = action_key_table[act];
      S_SCAN:    sel_code = 8'(code);
      default:   sel_code = toggle_key_code;
    endcase
  end

  krl_key_sel #(.NUM_KEYS(NUM_KEYS)) u_key_sel (
    .keys (snap),
    .code (sel_code),
    .down (key_down)
  );

  // codes already stored in earlier slots are skipped
  always_comb begin
    taken = 1'b0;
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      if ((SW'(i) < slot) && (action_key_table[i] == 8'(code))) taken = 1'b1;
    end
  end

  assign hit = key_down && !taken;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    key_in.ready = 1'b0;
    case (state)
      S_IDLE: begin
        key_in.ready = 1'b1;
        if (key_in.valid) state_next = S_TOGGLE;
      end
      S_TOGGLE: begin
        if (!learn_mode)                       state_next = S_BUTTONS;
        else if (key_down && !toggle_was_down) state_next = S_FINISH;
        else if (!key_down)                    state_next = S_SCAN;
        else                                   state_next = S_FINISH;
      end
      S_BUTTONS: begin
        if (act == AW'(NUM_ACTIONS - 1)) state_next = S_FINISH;
      end
      S_SCAN: begin
        if (hit && (slot == SW'(NUM_ACTIONS - 1))) state_next = S_FINISH;
        else if (code == KW'(NUM_KEYS - 1))        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      toggle_key_code <= TOGGLE_RESET;
      toggle_was_down <= 1'b1;
      learn_mode      <= 1'b0;
      slot            <= '0;
      out_valid       <= 1'b0;
      for (int i = 0; i < NUM_ACTIONS; i++) begin
        action_key_table[i] <= default_code(i);
      end
    end else begin
      if (cfg_we) toggle_key_code <= cfg_data;
      if ((state == S_FINISH) && out_free) out_valid <= 1'b1;
      else if (btn_out.ready)              out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            snap    <= in_bits[NUM_KEYS-1:0];
            buttons <= '0;
            done    <= 1'b0;
            act     <= '0;
            code    <= '0;
          end
        end
        S_TOGGLE: begin
          toggle_was_down <= key_down;
          tog_down        <= key_down;
          tog_edge        <= key_down && !toggle_was_down;
          if (learn_mode && key_down && !toggle_was_down) learn_mode <= 1'b0;
        end
        S_BUTTONS: begin
          buttons <= buttons | (8'(key_down) << act);
          act     <= act + AW'(1);
          if ((act == AW'(NUM_ACTIONS - 1)) && tog_edge) begin
            learn_mode <= 1'b1;
            slot       <= '0;
          end
        end
        S_SCAN: begin
          code <= code + KW'(1);
          if (hit) begin
            action_key_table[slot[AW-1:0]] <= 8'(code);
            slot <= slot + SW'(1);
            if (slot == SW'(NUM_ACTIONS - 1)) begin
              done       <= 1'b1;
              learn_mode <= 1'b0;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_buttons   <= buttons;
            out_learning  <= learn_mode;
            out_next_slot <= 4'(slot);
            out_done      <= done;
          end
        end
        default: ;
      endcase
    end
  end

  assign btn_out.valid          = out_valid;
  assign btn_out.action_buttons = out_buttons;
  assign btn_out.learning       = out_learning;
  assign btn_out.next_slot      = out_next_slot;
  assign btn_out.mapping_done   = out_done;

  a_done_leaves_learn: assert property (@(posedge clk) disable iff (rst)
    btn_out.valid && btn_out.mapping_done |-> !btn_out.learning)
    else $error("mapping_done with learn mode still active");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !key_in.ready)
    else $error("ready high right after a transaction");

  a_scan_in_learn: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> learn_mode && !tog_down)
    else $error("scan outside learn mode or with toggle key down");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SW'(NUM_ACTIONS))
    else $error("learn slot out of range");

endmodule

[design/krl_key_sel.sv]
module krl_key_sel #(
  parameter int NUM_KEYS = 256
) (
  input  logic [NUM_KEYS-1:0] keys,
  input  logic [7:0]          code,
  output logic                down
);

  localparam int KW = $clog2(NUM_KEYS);

  // codes at or above NUM_KEYS read as up
  assign down = ({1'b0, code} < 9'(NUM_KEYS)) ? keys[code[KW-1:0]] : 1'b0;

endmodule
